// ----- sv/counter_priority_thread_scheduler_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Concurrent assertion wrappers clocked on clk_i with rst_ni as disable.
// ----------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_THREAD_SCHEDULER_UNIT_ASSERT_SVH
`define COUNTER_PRIORITY_THREAD_SCHEDULER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define CPTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CPTS_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CPTS_ASSERT(name, prop, msg)
`define CPTS_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ----- sv/cpts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler package
// Widths, codes and shared records of the thread scheduler.
// ----------------------------------------------------------------------------
package cpts_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int OPC_W  = 3;
  localparam int TGT_W  = 4;
  localparam int PRI_W  = 6;
  localparam int CNT_W  = 7;
  localparam int TICK_W = 32;
  localparam int WK_W   = 5;
  localparam int OUT_W  = 4;

  localparam logic [PRI_W-1:0] IDLE_PRI_RST = PRI_W'(20);

  typedef enum logic [OPC_W-1:0] {
    OP_TICK  = 3'd0,
    OP_SLEEP = 3'd1,
    OP_BLOCK = 3'd2,
    OP_WAKE  = 3'd3,
    OP_ADD   = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_COUNT,
    ALU_DEC,
    ALU_SLEEP,
    ALU_BLOCK,
    ALU_WAKE,
    ALU_ADD,
    ALU_RECHARGE,
    ALU_PICK
  } alu_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_COUNT,
    ST_DEC,
    ST_PICK,
    ST_CHOOSE,
    ST_RECHARGE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic              valid;
    logic              asleep;
    logic              timed;
    logic [TICK_W-1:0] left;
    logic [PRI_W-1:0]  prio;
    logic [CNT_W-1:0]  cnt;
  } slot_t;

  typedef struct packed {
    alu_e              op;
    logic [SLOT_W-1:0] idx;
    logic              wr;
    logic [TICK_W-1:0] ticks;
    logic [PRI_W-1:0]  pri;
    logic              has_best;
    logic [CNT_W-1:0]  best;
  } ctl_t;

  typedef struct packed {
    slot_t nxt;
    logic  woke;
    logic  better;
  } alu_res_t;

  typedef struct packed {
    logic              load;
    logic [SLOT_W-1:0] slot;
    logic              switched;
    logic [WK_W-1:0]   wakeups;
    logic              rejected;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/counter_priority_thread_scheduler_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counter priority thread scheduler
// Slot table with countdown, time-slice pick and recharge for 16 threads.
// ----------------------------------------------------------------------------
// Usage: send one command word on the s_axis channel (opcode in tuser);
// every word returns exactly one result word on m_axis. The idle slot
// priority is written on the cfg channel, which is always ready; it must be
// written only while no command is in flight, which the block does not enforce.
// Flow, with N = 16 slots walked one per cycle through the shared slot ALU:
//   wake, add, rejected or unknown commands: at most one slot access
//   sleep, block: update of the running slot, then a pick pass, plus a
//   recharge pass and a re-pick when the picked count is zero
//   tick: a count pass and a decrement of the running slot; when its count
//   reaches zero, a pick pass with recharge and re-pick as needed
// One command is in work at a time; s_axis_tready is high only when idle,
// so a command holds the unit until its result is loaded for output.
// The result sits in an output register, so a new command is accepted while
// a finished result waits; a stalled receiver holds m_axis and halts the
// next command only when its result is ready to leave.
// Reset: slot 0 (idle thread) valid with priority and count 20, all other
// slots empty, slot 0 running, no result pending.
// ----------------------------------------------------------------------------
`include "counter_priority_thread_scheduler_unit_assert.svh"

module counter_priority_thread_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // target_slot[3:0], thread_priority_in[9:4],
                                     // sleep_ticks[41:10], zero[47:42]
  input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // running_slot[3:0], switched[4], wakeups[9:5],
                                     // rejected[10], zero[15:11]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i
);

  logic                          valid_q  [cpts_pkg::SLOTS];
  logic                          asleep_q [cpts_pkg::SLOTS];
  logic                          timed_q  [cpts_pkg::SLOTS];
  logic [cpts_pkg::TICK_W-1:0]   left_q   [cpts_pkg::SLOTS];
  logic [cpts_pkg::PRI_W-1:0]    prio_q   [cpts_pkg::SLOTS];
  logic [cpts_pkg::CNT_W-1:0]    cnt_q    [cpts_pkg::SLOTS];

  cpts_pkg::slot_t    rd;
  cpts_pkg::ctl_t     ctl;
  cpts_pkg::alu_res_t alu;
  cpts_pkg::res_t     res;
  logic               m_valid_q;
  logic [15:0]        m_data_q;
  logic               out_free;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign rd.valid  = valid_q[ctl.idx];
  assign rd.asleep = asleep_q[ctl.idx];
  assign rd.timed  = timed_q[ctl.idx];
  assign rd.left   = left_q[ctl.idx];
  assign rd.prio   = prio_q[ctl.idx];
  assign rd.cnt    = cnt_q[ctl.idx];

  cpts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_opcode_i (s_axis_tuser),
    .in_tgt_i    (s_axis_tdata[3:0]),
    .in_pri_i    (s_axis_tdata[9:4]),
    .in_ticks_i  (s_axis_tdata[41:10]),
    .out_free_i  (out_free),
    .rd_i        (rd),
    .alu_i       (alu),
    .ctl_o       (ctl),
    .res_o       (res)
  );

  cpts_slot_alu u_alu (
    .ctl_i (ctl),
    .rd_i  (rd),
    .res_o (alu)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cpts_pkg::SLOTS; i++) begin
        valid_q[i]  <= (i == 0);
        asleep_q[i] <= 1'b0;
        timed_q[i]  <= 1'b0;
        prio_q[i]   <= (i == 0) ? cpts_pkg::IDLE_PRI_RST : '0;
        cnt_q[i]    <= (i == 0) ? cpts_pkg::CNT_W'(cpts_pkg::IDLE_PRI_RST) : '0;
      end
    end else begin
      if (ctl.wr) begin
        valid_q[ctl.idx]  <= alu.nxt.valid;
        asleep_q[ctl.idx] <= alu.nxt.asleep;
        timed_q[ctl.idx]  <= alu.nxt.timed;
        prio_q[ctl.idx]   <= alu.nxt.prio;
        cnt_q[ctl.idx]    <= alu.nxt.cnt;
      end
      if (cfg_valid_i) begin
        prio_q[0] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.wr) begin
      left_q[ctl.idx] <= alu.nxt.left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res.load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      m_data_q <= {5'b0, res.rejected, res.wakeups, res.switched,
                   cpts_pkg::OUT_W'(res.slot)};
    end
  end

  `CPTS_ASSERT(a_idle_slot_valid, valid_q[0], "idle slot lost its valid bit")
  `CPTS_ASSERT(a_cur_slot_valid, valid_q[res.slot], "running slot is not valid")
  `CPTS_ASSERT(a_load_when_free, res.load |-> out_free, "result overwrote a pending word")
  `CPTS_ASSERT_NEVER(a_no_idle_recharge, ctl.wr && (ctl.op == cpts_pkg::ALU_RECHARGE) && (ctl.idx == '0), "recharge touched the idle slot")

endmodule
`default_nettype wire

// ----- sv/cpts_slot_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler slot ALU
// Shared per-slot update and compare unit, one slot entry per cycle.
// ----------------------------------------------------------------------------
module cpts_slot_alu (
  input  cpts_pkg::ctl_t     ctl_i,
  input  cpts_pkg::slot_t    rd_i,
  output cpts_pkg::alu_res_t res_o
);

  logic [cpts_pkg::TICK_W-1:0] left_m1;

  assign left_m1 = rd_i.left - cpts_pkg::TICK_W'(1);

  always_comb begin
    res_o.nxt    = rd_i;
    res_o.woke   = 1'b0;
    res_o.better = 1'b0;
    case (ctl_i.op)
      cpts_pkg::ALU_COUNT: begin
        if (rd_i.valid && rd_i.asleep && rd_i.timed) begin
          res_o.nxt.left = left_m1;
          if (left_m1 == '0) begin
            res_o.nxt.asleep = 1'b0;
            res_o.nxt.timed  = 1'b0;
            res_o.nxt.cnt    = cpts_pkg::CNT_W'(rd_i.prio);
            res_o.woke       = 1'b1;
          end
        end
      end
      cpts_pkg::ALU_DEC: begin
        if (rd_i.cnt != '0) begin
          res_o.nxt.cnt = rd_i.cnt - cpts_pkg::CNT_W'(1);
        end
      end
      cpts_pkg::ALU_SLEEP: begin
        res_o.nxt.asleep = 1'b1;
        res_o.nxt.timed  = 1'b1;
        res_o.nxt.left   = (ctl_i.ticks == '0) ? cpts_pkg::TICK_W'(1) : ctl_i.ticks;
      end
      cpts_pkg::ALU_BLOCK: begin
        res_o.nxt.asleep = 1'b1;
      end
      cpts_pkg::ALU_WAKE: begin
        if (rd_i.valid && rd_i.asleep) begin
          res_o.nxt.asleep = 1'b0;
          res_o.nxt.timed  = 1'b0;
          res_o.nxt.left   = '0;
          res_o.nxt.cnt    = cpts_pkg::CNT_W'(rd_i.prio);
        end
      end
      cpts_pkg::ALU_ADD: begin
        res_o.nxt.valid  = 1'b1;
        res_o.nxt.asleep = 1'b0;
        res_o.nxt.timed  = 1'b0;
        res_o.nxt.left   = '0;
        res_o.nxt.prio   = ctl_i.pri;
        res_o.nxt.cnt    = cpts_pkg::CNT_W'(ctl_i.pri);
      end
      cpts_pkg::ALU_RECHARGE: begin
        if (rd_i.valid) begin
          res_o.nxt.cnt = {1'b0, rd_i.cnt[cpts_pkg::CNT_W-1:1]}
                          + cpts_pkg::CNT_W'(rd_i.prio);
        end
      end
      cpts_pkg::ALU_PICK: begin
        res_o.better = rd_i.valid && !rd_i.asleep
                       && (!ctl_i.has_best || (rd_i.cnt > ctl_i.best));
      end
      default: begin
        res_o.nxt = rd_i;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/cpts_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Runs each accepted word through the shared ALU, walking the slot table for tick, sleep and block.
// ----------------------------------------------------------------------------
module cpts_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cpts_pkg::OPC_W-1:0]   in_opcode_i,
  input  logic [cpts_pkg::TGT_W-1:0]   in_tgt_i,
  input  logic [cpts_pkg::PRI_W-1:0]   in_pri_i,
  input  logic [cpts_pkg::TICK_W-1:0]  in_ticks_i,
  input  logic                         out_free_i,
  input  cpts_pkg::slot_t              rd_i,
  input  cpts_pkg::alu_res_t           alu_i,
  output cpts_pkg::ctl_t               ctl_o,
  output cpts_pkg::res_t               res_o
);

  localparam logic [cpts_pkg::SLOT_W-1:0] LAST = cpts_pkg::SLOT_W'(cpts_pkg::SLOTS - 1);
  localparam logic [cpts_pkg::SLOT_W-1:0] ONE  = cpts_pkg::SLOT_W'(1);

  cpts_pkg::state_e              state_q, state_d;
  logic [cpts_pkg::SLOT_W-1:0]   idx_q, idx_d;
  logic [cpts_pkg::OPC_W-1:0]    op_q, op_d;
  logic [cpts_pkg::PRI_W-1:0]    pri_q, pri_d;
  logic [cpts_pkg::TICK_W-1:0]   ticks_q, ticks_d;
  logic [cpts_pkg::SLOT_W-1:0]   cur_q, cur_d;
  logic [cpts_pkg::WK_W-1:0]     wk_q, wk_d;
  logic                          rej_q, rej_d;
  logic                          sw_q, sw_d;
  logic                          rchg_q, rchg_d;
  logic                          def_q, def_d;
  logic                          has_best_q, has_best_d;
  logic [cpts_pkg::CNT_W-1:0]    best_q, best_d;
  logic [cpts_pkg::SLOT_W-1:0]   pick_q, pick_d;
  logic [cpts_pkg::CNT_W-1:0]    pick_cnt_q, pick_cnt_d;
  logic                          tgt_in_range;

  assign tgt_in_range = (32'(in_tgt_i) < cpts_pkg::SLOTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cpts_pkg::ST_IDLE;
      idx_q      <= '0;
      cur_q      <= '0;
      wk_q       <= '0;
      rej_q      <= 1'b0;
      sw_q       <= 1'b0;
      rchg_q     <= 1'b0;
      def_q      <= 1'b0;
      has_best_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      cur_q      <= cur_d;
      wk_q       <= wk_d;
      rej_q      <= rej_d;
      sw_q       <= sw_d;
      rchg_q     <= rchg_d;
      def_q      <= def_d;
      has_best_q <= has_best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pri_q      <= pri_d;
    ticks_q    <= ticks_d;
    best_q     <= best_d;
    pick_q     <= pick_d;
    pick_cnt_q <= pick_cnt_d;
  end

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    op_d           = op_q;
    pri_d          = pri_q;
    ticks_d        = ticks_q;
    cur_d          = cur_q;
    wk_d           = wk_q;
    rej_d          = rej_q;
    sw_d           = sw_q;
    rchg_d         = rchg_q;
    def_d          = def_q;
    has_best_d     = has_best_q;
    best_d         = best_q;
    pick_d         = pick_q;
    pick_cnt_d     = pick_cnt_q;
    in_ready_o     = 1'b0;
    ctl_o.op       = cpts_pkg::ALU_NONE;
    ctl_o.idx      = idx_q;
    ctl_o.wr       = 1'b0;
    ctl_o.ticks    = ticks_q;
    ctl_o.pri      = pri_q;
    ctl_o.has_best = has_best_q;
    ctl_o.best     = best_q;
    res_o.load     = 1'b0;
    res_o.slot     = cur_q;
    res_o.switched = sw_q;
    res_o.wakeups  = wk_q;
    res_o.rejected = rej_q;

    case (state_q)
      cpts_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = in_opcode_i;
          pri_d   = in_pri_i;
          ticks_d = in_ticks_i;
          wk_d    = '0;
          rej_d   = 1'b0;
          sw_d    = 1'b0;
          rchg_d  = 1'b0;
          state_d = cpts_pkg::ST_FIN;
          case (in_opcode_i)
            cpts_pkg::OP_TICK: begin
              idx_d   = '0;
              state_d = cpts_pkg::ST_COUNT;
            end
            cpts_pkg::OP_SLEEP: begin
              if (cur_q == '0) begin
                rej_d = 1'b1;
              end else begin
                idx_d   = cur_q;
                state_d = cpts_pkg::ST_SLOT;
              end
            end
            cpts_pkg::OP_BLOCK: begin
              idx_d   = cur_q;
              state_d = cpts_pkg::ST_SLOT;
            end
            cpts_pkg::OP_WAKE: begin
              if (tgt_in_range) begin
                idx_d   = cpts_pkg::SLOT_W'(in_tgt_i);
                state_d = cpts_pkg::ST_SLOT;
              end
            end
            cpts_pkg::OP_ADD: begin
              if (tgt_in_range && (in_tgt_i != '0)) begin
                idx_d   = cpts_pkg::SLOT_W'(in_tgt_i);
                state_d = cpts_pkg::ST_SLOT;
              end else begin
                rej_d = 1'b1;
              end
            end
            default: begin
              state_d = cpts_pkg::ST_FIN;
            end
          endcase
        end
      end
      cpts_pkg::ST_SLOT: begin
        state_d = cpts_pkg::ST_FIN;
        case (op_q)
          cpts_pkg::OP_SLEEP, cpts_pkg::OP_BLOCK: begin
            ctl_o.op   = (op_q == cpts_pkg::OP_SLEEP) ? cpts_pkg::ALU_SLEEP
                                                      : cpts_pkg::ALU_BLOCK;
            ctl_o.wr   = 1'b1;
            idx_d      = ONE;
            def_d      = 1'b0;
            has_best_d = 1'b0;
            state_d    = cpts_pkg::ST_PICK;
          end
          cpts_pkg::OP_WAKE: begin
            ctl_o.op = cpts_pkg::ALU_WAKE;
            ctl_o.wr = 1'b1;
          end
          cpts_pkg::OP_ADD: begin
            if (rd_i.valid) begin
              rej_d = 1'b1;
            end else begin
              ctl_o.op = cpts_pkg::ALU_ADD;
              ctl_o.wr = 1'b1;
            end
          end
          default: begin
            state_d = cpts_pkg::ST_FIN;
          end
        endcase
      end
      cpts_pkg::ST_COUNT: begin
        ctl_o.op = cpts_pkg::ALU_COUNT;
        ctl_o.wr = 1'b1;
        if (alu_i.woke) begin
          wk_d = wk_q + cpts_pkg::WK_W'(1);
        end
        if (idx_q == LAST) begin
          idx_d   = cur_q;
          state_d = cpts_pkg::ST_DEC;
        end else begin
          idx_d = idx_q + ONE;
        end
      end
      cpts_pkg::ST_DEC: begin
        ctl_o.op = cpts_pkg::ALU_DEC;
        ctl_o.wr = 1'b1;
        if (alu_i.nxt.cnt == '0) begin
          idx_d      = ONE;
          def_d      = 1'b0;
          has_best_d = 1'b0;
          state_d    = cpts_pkg::ST_PICK;
        end else begin
          state_d = cpts_pkg::ST_FIN;
        end
      end
      cpts_pkg::ST_PICK: begin
        ctl_o.op = cpts_pkg::ALU_PICK;
        if (rd_i.valid && !def_q) begin
          def_d      = 1'b1;
          pick_d     = idx_q;
          pick_cnt_d = rd_i.cnt;
        end
        if (alu_i.better) begin
          has_best_d = 1'b1;
          best_d     = rd_i.cnt;
          pick_d     = idx_q;
          pick_cnt_d = rd_i.cnt;
        end
        if (idx_q == '0) begin
          state_d = cpts_pkg::ST_CHOOSE;
        end else if (idx_q == LAST) begin
          idx_d = '0;
        end else begin
          idx_d = idx_q + ONE;
        end
      end
      cpts_pkg::ST_CHOOSE: begin
        if ((pick_cnt_q == '0) && !rchg_q) begin
          rchg_d  = 1'b1;
          idx_d   = ONE;
          state_d = cpts_pkg::ST_RECHARGE;
        end else begin
          sw_d    = (pick_q != cur_q);
          cur_d   = pick_q;
          state_d = cpts_pkg::ST_FIN;
        end
      end
      cpts_pkg::ST_RECHARGE: begin
        ctl_o.op = cpts_pkg::ALU_RECHARGE;
        ctl_o.wr = 1'b1;
        if (idx_q == LAST) begin
          idx_d      = ONE;
          def_d      = 1'b0;
          has_best_d = 1'b0;
          state_d    = cpts_pkg::ST_PICK;
        end else begin
          idx_d = idx_q + ONE;
        end
      end
      cpts_pkg::ST_FIN: begin
        if (out_free_i) begin
          res_o.load = 1'b1;
          state_d    = cpts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cpts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
